// File: rtl/core/color_difference_edge_detect_unit_macros.svh
// Assertion macros shared by the edge detector RTL.
`ifndef COLOR_DIFFERENCE_EDGE_DETECT_UNIT_MACROS_SVH
`define COLOR_DIFFERENCE_EDGE_DETECT_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CDED_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CDED_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cded_pkg.sv
// Types and constants shared by the color difference edge detector.
package cded_pkg;

	localparam int RGB_W      = 24;
	localparam int ROW_OUT_W  = 12;
	localparam int COL_OUT_W  = 10;
	localparam int CFG_W_BITS = 11;
	localparam int CFG_H_BITS = 13;
	localparam int CFG_T_BITS = 9;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int LIM_W      = 19;
	localparam int HROW_W     = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic METRIC_MAX    = 1'b0;
	localparam logic METRIC_EUCLID = 1'b1;

	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] BLACK_RGB = 24'h000000;

	localparam logic [CFG_W_BITS-1:0] WIDTH_RST     = 11'd640;
	localparam logic [CFG_H_BITS-1:0] HEIGHT_RST    = 13'd480;
	localparam logic [CFG_T_BITS-1:0] THRESHOLD_RST = 9'd32;
	localparam logic                  MODE_RST      = METRIC_MAX;
	localparam logic [LIM_W-1:0]      LIM_RST       = LIM_W'((32 + 1) * (32 + 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2,
		REG_METRIC_MODE    = 2'd3
	} cfg_reg_t;

	typedef logic [RGB_W-1:0] rgb_t;

	// Indexed [row][col]; row 0 is the upper line, col 2 the newest column.
	typedef rgb_t [2:0][2:0] win_t;

	typedef struct packed {
		logic operation;
		rgb_t pixel_rgb;
	} in_item_t;

	typedef struct packed {
		rgb_t                 edge_pixel;
		logic                 is_edge;
		logic [ROW_OUT_W-1:0] out_row;
		logic [COL_OUT_W-1:0] out_col;
		logic                 frame_end;
	} out_item_t;

	// Which neighbor rows and columns lie inside the image.
	typedef struct packed {
		logic [2:0] row_ok;
		logic       left_ok;
		logic       right_ok;
	} eval_ctl_t;

	typedef struct packed {
		logic                  mode;
		logic [CFG_T_BITS-1:0] thresh;
		logic [LIM_W-1:0]      lim;
	} metric_cfg_t;

endpackage

// File: rtl/core/cded_line_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cded_line_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/cded_eval.sv
// Compares the window center against its in-bounds neighbors.
module cded_eval
	import cded_pkg::*;
(
	input  win_t        view,
	input  eval_ctl_t   ctl,
	input  metric_cfg_t metric,
	output logic        hit
);

	logic [2:0]      col_ok;
	logic [2:0][2:0] hits;

	function automatic logic [7:0] absd(logic [7:0] a, logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic differs(rgb_t p, rgb_t q, metric_cfg_t m);
		logic [7:0]  dr;
		logic [7:0]  dg;
		logic [7:0]  db;
		logic [17:0] sq;
		logic        res;
		dr = absd(p[23:16], q[23:16]);
		dg = absd(p[15:8], q[15:8]);
		db = absd(p[7:0], q[7:0]);
		sq = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
		if (m.mode == METRIC_EUCLID) begin
			res = LIM_W'(sq) >= m.lim;
		end else begin
			res = (CFG_T_BITS'(dr) > m.thresh) || (CFG_T_BITS'(dg) > m.thresh) ||
				(CFG_T_BITS'(db) > m.thresh);
		end
		return res;
	endfunction

	assign col_ok = {ctl.right_ok, 1'b1, ctl.left_ok};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				hits[r][c] = ctl.row_ok[r] && col_ok[c] && !((r == 1) && (c == 1)) &&
					differs(view[1][1], view[r][c], metric);
			end
		end
	end

	assign hit = |hits;

endmodule

// File: rtl/core/color_difference_edge_detect_unit.sv
// Top level of the streaming 3x3 color difference edge detector.
//
// channel  handshake             payload               role
// pix      pix_valid, pix_stall  pix_data (in_item_t)  pixels and drain ticks, raster order
// det      det_valid, det_stall  det_data (out_item_t) one black or white mark per pixel
// cfg      cfg_we                cfg_index, cfg_wdata  register writes, no read-back
//
// One request is accepted per clock while pix_stall is low. The mark for a pixel is produced by the pixel or flush
// request image_width+1 places later: the line RAM read and the working stage load when that request
// is accepted, and the output register, which drives det_valid, loads when the working stage advances.
// Reset clears the counters, the window and the valid flags; the line RAM is not cleared.
// pix_stall rises only when the working stage holds a request with a mark, the output
// register is occupied and det_stall is high.
`include "color_difference_edge_detect_unit_macros.svh"

module color_difference_edge_detect_unit
	import cded_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  in_item_t              pix_data,
	output logic                  det_valid,
	input  logic                  det_stall,
	output out_item_t             det_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int WW    = AW + 1;
	localparam int XW    = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;
	localparam int CPW   = WW + 1;
	localparam int PW    = $clog2(MAX_WIDTH + 2);
	localparam int RW    = $clog2(MAX_HEIGHT + MAX_WIDTH + 3);
	localparam int RAM_W = 2 * RGB_W;

	// Configuration registers.
	logic [CFG_W_BITS-1:0] image_width_q;
	logic [CFG_H_BITS-1:0] image_height_q;
	logic [CFG_T_BITS-1:0] threshold_q;
	logic                  mode_q;
	logic [LIM_W-1:0]      lim_q;
	logic [9:0]            thresh_inc;
	logic [19:0]           thresh_sq;
	metric_cfg_t           metric;

	logic [XW-1:0]     w_ext;
	logic [WW-1:0]     eff_w;
	logic [HROW_W-1:0] eff_h;

	// Position counters.
	logic [AW-1:0]     in_col_q;
	logic [RW-1:0]     in_row_q;
	logic [AW-1:0]     out_col_q;
	logic [HROW_W-1:0] out_row_q;
	logic [PW-1:0]     pending_q;

	logic              in_wrap;
	logic [AW-1:0]     in_col_a;
	logic [RW-1:0]     in_row_a;
	logic              out_wrap;
	logic [AW-1:0]     out_col_a;
	logic [HROW_W-1:0] out_row_a;
	logic [WW-1:0]     in_col_inc;
	logic              in_step_wrap;
	logic [AW-1:0]     in_col_b;
	logic [RW-1:0]     in_row_b;
	logic [WW-1:0]     out_col_inc;
	logic              out_last_col;
	logic [AW-1:0]     out_col_b;
	logic [HROW_W-1:0] out_row_b;
	logic              flushing;
	logic              work;
	logic              emit_a;
	logic              last_a;
	rgb_t              pixel_eff;
	eval_ctl_t         ctl_a;
	logic              acc;
	logic              load;

	// Working stage.
	logic                 s1_valid_q;
	logic                 s1_adv;
	rgb_t                 pix_s1;
	logic [AW-1:0]        col_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic [ROW_OUT_W-1:0] orow_s1;
	logic [COL_OUT_W-1:0] ocol_s1;
	eval_ctl_t            ctl_s1;
	logic                 fwd_s1;
	logic [RAM_W-1:0]     fwd_data_s1;

	logic [RAM_W-1:0] ram_rdata;
	logic [RAM_W-1:0] ram_wdata;
	rgb_t             line_up;
	rgb_t             line_mid;
	win_t             win_q;
	win_t             win_next;
	logic             edge_hit;

	// Output register.
	logic      det_valid_q;
	out_item_t det_data_q;

	// ---------------------------------------------------------------- configuration

	assign thresh_inc = 10'(cfg_wdata[CFG_T_BITS-1:0]) + 10'd1;
	assign thresh_sq  = 20'(thresh_inc) * 20'(thresh_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
			threshold_q    <= THRESHOLD_RST;
			mode_q         <= MODE_RST;
			lim_q          <= LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wdata[CFG_W_BITS-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wdata[CFG_H_BITS-1:0];
				end
				REG_EDGE_THRESHOLD: begin
					threshold_q <= cfg_wdata[CFG_T_BITS-1:0];
					// Squared limit for the Euclidean metric, kept alongside the threshold.
					lim_q       <= thresh_sq[LIM_W-1:0];
				end
				REG_METRIC_MODE: begin
					mode_q <= cfg_wdata[0];
				end
			endcase
		end
	end

	assign metric.mode   = mode_q;
	assign metric.thresh = threshold_q;
	assign metric.lim    = lim_q;

	assign w_ext = XW'(image_width_q);
	assign eff_w = (image_width_q == '0) ? WW'(1) :
		((w_ext > XW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext));
	assign eff_h = (image_height_q == '0) ? HROW_W'(1) :
		((image_height_q > HROW_W'(MAX_HEIGHT)) ? HROW_W'(MAX_HEIGHT) : image_height_q);

	// ---------------------------------------------------------------- request control

	// Counters left beyond a narrowed width wrap before the request is looked at.
	assign in_wrap   = WW'(in_col_q) >= eff_w;
	assign in_col_a  = in_wrap ? '0 : in_col_q;
	assign in_row_a  = in_wrap ? (in_row_q + RW'(1)) : in_row_q;
	assign out_wrap  = WW'(out_col_q) >= eff_w;
	assign out_col_a = out_wrap ? '0 : out_col_q;
	assign out_row_a = out_wrap ? (out_row_q + HROW_W'(1)) : out_row_q;

	assign in_col_inc   = WW'(in_col_a) + WW'(1);
	assign in_step_wrap = in_col_inc >= eff_w;
	assign in_col_b     = in_step_wrap ? '0 : in_col_inc[AW-1:0];
	assign in_row_b     = in_step_wrap ? (in_row_a + RW'(1)) : in_row_a;

	assign out_col_inc  = WW'(out_col_a) + WW'(1);
	assign out_last_col = out_col_inc >= eff_w;
	assign out_col_b    = out_last_col ? '0 : out_col_inc[AW-1:0];
	assign out_row_b    = out_last_col ? (out_row_a + HROW_W'(1)) : out_row_a;

	// Once all pixels of the frame are in, every request drains a zero pixel.
	assign flushing  = in_row_a >= RW'(eff_h);
	assign work      = flushing ? (pending_q != '0) : (pix_data.operation == OP_PIXEL);
	assign pixel_eff = flushing ? '0 : pix_data.pixel_rgb;
	assign emit_a    = CPW'(pending_q) >= (CPW'(eff_w) + CPW'(1));
	assign last_a    = emit_a && ((out_row_a >= eff_h) ||
		((out_row_a == (eff_h - HROW_W'(1))) && out_last_col));

	assign ctl_a.row_ok[0] = (out_row_a != '0) && (out_row_a <= eff_h);
	assign ctl_a.row_ok[1] = out_row_a < eff_h;
	assign ctl_a.row_ok[2] = ((HROW_W + 1)'(out_row_a) + (HROW_W + 1)'(1)) <
		(HROW_W + 1)'(eff_h);
	assign ctl_a.left_ok   = out_col_a != '0;
	assign ctl_a.right_ok  = !out_last_col;

	assign acc  = pix_valid && !pix_stall;
	assign load = acc && work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (acc) begin
			priority if (!work) begin
				in_col_q  <= in_col_a;
				in_row_q  <= in_row_a;
				out_col_q <= out_col_a;
				out_row_q <= out_row_a;
			end else if (!emit_a) begin
				in_col_q  <= in_col_b;
				in_row_q  <= in_row_b;
				out_col_q <= out_col_a;
				out_row_q <= out_row_a;
				pending_q <= pending_q + PW'(1);
			end else if (last_a) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pending_q <= '0;
			end else begin
				in_col_q  <= in_col_b;
				in_row_q  <= in_row_b;
				out_col_q <= out_col_b;
				out_row_q <= out_row_b;
			end
		end
	end

	// ---------------------------------------------------------------- working stage

	assign s1_adv    = s1_valid_q && (!emit_s1 || !det_valid_q || !det_stall);
	assign pix_stall = s1_valid_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1      <= pixel_eff;
			col_s1      <= in_col_a;
			emit_s1     <= emit_a;
			last_s1     <= last_a;
			orow_s1     <= out_row_a[ROW_OUT_W-1:0];
			ocol_s1     <= COL_OUT_W'(out_col_a);
			ctl_s1      <= ctl_a;
			// The RAM returns the old entry when the leaving request writes the same column.
			fwd_s1      <= s1_adv && (col_s1 == in_col_a);
			fwd_data_s1 <= ram_wdata;
		end
	end

	cded_line_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (load),
		.raddr (in_col_a),
		.rdata (ram_rdata)
	);

	assign line_up   = fwd_s1 ? fwd_data_s1[RAM_W-1:RGB_W] : ram_rdata[RAM_W-1:RGB_W];
	assign line_mid  = fwd_s1 ? fwd_data_s1[RGB_W-1:0] : ram_rdata[RGB_W-1:0];
	assign ram_wdata = {line_mid, pix_s1};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r][0] = win_q[r][1];
			win_next[r][1] = win_q[r][2];
		end
		win_next[0][2] = line_up;
		win_next[1][2] = line_mid;
		win_next[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_next;
		end
	end

	// After the shift the center always sits in the middle column; at the end of a row
	// the right column is out of bounds and masked.
	cded_eval u_eval (
		.view   (win_next),
		.ctl    (ctl_s1),
		.metric (metric),
		.hit    (edge_hit)
	);

	// ---------------------------------------------------------------- output register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			det_valid_q <= 1'b1;
		end else if (!det_stall) begin
			det_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			det_data_q <= '{
				edge_pixel: edge_hit ? BLACK_RGB : WHITE_RGB,
				is_edge:    edge_hit,
				out_row:    orow_s1,
				out_col:    ocol_s1,
				frame_end:  last_s1
			};
		end
	end

	assign det_valid = det_valid_q;
	assign det_data  = det_data_q;

	// ---------------------------------------------------------------- assertions

	`CDED_ASSERT_NEXT(a_frame_end_clears, load && emit_a && last_a, (in_col_q == '0) && (out_col_q == '0) && (pending_q == '0), "counters not cleared after the last pixel of a frame")
	`CDED_ASSERT_SAME(a_ram_read_free, load, !s1_valid_q || s1_adv, "line RAM read while the working stage is held")
	`CDED_ASSERT_SAME(a_stall_needs_full, pix_stall, s1_valid_q && emit_s1 && det_valid_q && det_stall, "request stalled while the pipeline has room")

endmodule

// File: bench/color_difference_edge_detect_unit_checker.sv
// Checker for the edge detector: tracks its registers, predicts every mark, compares outputs.
module color_difference_edge_detect_unit_checker
	import cded_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  in_item_t              pix_data,
	input  logic                  det_valid,
	input  logic                  det_stall,
	input  out_item_t             det_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mark_errors,
	output int                    marks_pending,
	output int                    marks_checked,
	output int                    edge_marks
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W_BITS-1:0] reg_width;
	logic [CFG_H_BITS-1:0] reg_height;
	logic [CFG_T_BITS-1:0] reg_thresh;
	logic                  reg_mode;

	rgb_t upper_store [MAX_WIDTH];
	rgb_t middle_store [MAX_WIDTH];
	win_t win;
	int   in_row, in_col, out_row, out_col, fill;

	out_item_t marks_due [$];

	function automatic bit colors_differ(rgb_t a, rgb_t b);
		int gap [3];
		int k, widest, lim;
		for (k = 0; k < 3; k++) begin
			gap[k] = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
			if (gap[k] < 0) gap[k] = -gap[k];
		end
		if (reg_mode == METRIC_EUCLID) begin
			lim = (int'(reg_thresh) + 1) * (int'(reg_thresh) + 1);
			return gap[0] * gap[0] + gap[1] * gap[1] + gap[2] * gap[2] >= lim;
		end
		widest = gap[0];
		if (gap[1] > widest) widest = gap[1];
		if (gap[2] > widest) widest = gap[2];
		return widest > int'(reg_thresh);
	endfunction

	// The center sits in window column cc; only neighbors inside the image count.
	function automatic bit neighbor_edge(int orow, int ocol, int cc, int w, int h);
		rgb_t centre;
		int   dr, dc, r, c, wc;
		centre = win[1][cc];
		for (dr = -1; dr <= 1; dr++) begin
			r = orow + dr;
			if (r < 0 || r >= h) continue;
			for (dc = -1; dc <= 1; dc++) begin
				c = ocol + dc;
				wc = cc + dc;
				if (c < 0 || c >= w || wc < 0 || wc > 2) continue;
				if (colors_differ(centre, win[dr + 1][wc])) return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic advance_window(in_item_t req);
		int        w, h, col, r;
		rgb_t      pix, up, mid;
		bit        emit, pre, hit, last;
		out_item_t mark;
		w = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width));
		h = (reg_height == 0) ? 1 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height));
		pix = req.pixel_rgb;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		// Once the last row is in, every request flushes a black pixel through the window.
		if (in_row >= h) begin
			if (fill == 0) return;
			pix = BLACK_RGB;
		end else if (req.operation == OP_DRAIN) begin
			return;
		end
		emit = fill >= w + 1;
		pre = emit && (out_col + 1 >= w);
		hit = 1'b0;
		if (pre) hit = neighbor_edge(out_row, out_col, 2, w, h);
		col = in_col;
		up = '0;
		mid = '0;
		if (col < MAX_WIDTH) begin
			up = upper_store[col];
			mid = middle_store[col];
		end
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = pix;
		if (col < MAX_WIDTH) begin
			upper_store[col] = mid;
			middle_store[col] = pix;
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit) begin
			fill++;
			return;
		end
		if (!pre) hit = neighbor_edge(out_row, out_col, 1, w, h);
		last = out_row * w + out_col + 1 >= w * h;
		mark.edge_pixel = hit ? BLACK_RGB : WHITE_RGB;
		mark.is_edge = hit;
		mark.out_row = ROW_OUT_W'(out_row);
		mark.out_col = COL_OUT_W'(out_col);
		mark.frame_end = last;
		marks_due.push_back(mark);
		if (last) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			fill = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t due;
		if (!arst_n) begin
			reg_width = WIDTH_RST;
			reg_height = HEIGHT_RST;
			reg_thresh = THRESHOLD_RST;
			reg_mode = MODE_RST;
			foreach (upper_store[i]) begin
				upper_store[i] = '0;
				middle_store[i] = '0;
			end
			win = '0;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			fill = 0;
			marks_due.delete();
			mark_errors = 0;
			marks_checked = 0;
			edge_marks = 0;
			marks_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:    reg_width = cfg_wdata[CFG_W_BITS-1:0];
					REG_IMAGE_HEIGHT:   reg_height = cfg_wdata[CFG_H_BITS-1:0];
					REG_EDGE_THRESHOLD: reg_thresh = cfg_wdata[CFG_T_BITS-1:0];
					REG_METRIC_MODE:    reg_mode = cfg_wdata[0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) advance_window(pix_data);
			if (det_valid && !det_stall) begin
				marks_checked++;
				if (det_data.is_edge === 1'b1) edge_marks++;
				if (marks_due.size() == 0) begin
					mark_errors++;
					$display("%0t ns: unexpected mark, expected none, got pixel %h edge %b row %0d col %0d last %b",
						$time, det_data.edge_pixel, det_data.is_edge, det_data.out_row,
						det_data.out_col, det_data.frame_end);
				end else begin
					due = marks_due.pop_front();
					if (det_data !== due) begin
						mark_errors++;
						if (mark_errors <= 100) begin
							$display("%0t ns: mark mismatch, expected pixel %h edge %b row %0d col %0d last %b, got pixel %h edge %b row %0d col %0d last %b",
								$time, due.edge_pixel, due.is_edge, due.out_row, due.out_col,
								due.frame_end, det_data.edge_pixel, det_data.is_edge,
								det_data.out_row, det_data.out_col, det_data.frame_end);
						end
					end
				end
			end
			marks_pending <= marks_due.size();
		end
	end

endmodule

// File: bench/color_difference_edge_detect_unit_tb.sv
// Top of the edge detector bench: clock, reset, pixel stimulus, output stalls and verdict.
module color_difference_edge_detect_unit_tb;
	import cded_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 350;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 600000;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_RARE,
		STALL_EVERY_THIRD
	} stall_style_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	in_item_t              pix_data = '0;
	logic                  det_valid;
	logic                  det_stall = 1'b0;
	out_item_t             det_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int mark_errors, marks_pending, marks_checked, edge_marks;
	int cycle_count = 0;
	int hold_req = 0;
	int burst_left = 5;
	int requests_sent = 0;
	int stream_items = 0;
	int frames_sent = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	color_difference_edge_detect_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.det_valid (det_valid),
		.det_stall (det_stall),
		.det_data  (det_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	color_difference_edge_detect_unit_checker mark_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pix_data      (pix_data),
		.det_valid     (det_valid),
		.det_stall     (det_stall),
		.det_data      (det_data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mark_errors   (mark_errors),
		.marks_pending (marks_pending),
		.marks_checked (marks_checked),
		.edge_marks    (edge_marks)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t ns: timed out with %0d marks outstanding", $time, marks_pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Output side: stall styles change every segment; a hold request from the stimulus
	// freezes the output for a long stretch.
	initial begin : output_stalls
		stall_style_t style;
		int           seg, tick, hold_ack;
		hold_ack = 0;
		tick = 0;
		forever begin
			seg = $urandom_range(20, 200);
			style = stall_style_t'($urandom_range(0, 3));
			repeat (seg) begin
				@(posedge clk);
				tick++;
				if (hold_req != hold_ack) begin
					det_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
					hold_ack = hold_req;
				end
				case (style)
					STALL_NONE:        det_stall <= 1'b0;
					STALL_COIN:        det_stall <= ($urandom_range(0, 1) == 1);
					STALL_RARE:        det_stall <= ($urandom_range(0, 7) == 0);
					STALL_EVERY_THIRD: det_stall <= (tick % 3 == 0);
					default:           det_stall <= 1'b0;
				endcase
			end
		end
	end

	// Offers one request and waits for it to be taken; bursts end in a short gap.
	task automatic send(logic op, rgb_t colour);
		pix_valid <= 1'b1;
		pix_data <= '{operation: op, pixel_rgb: colour};
		do @(posedge clk); while (pix_stall);
		requests_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
	endtask

	// Stops sending and waits until every mark has come out and the pipeline is empty.
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (marks_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(int width, int height, int thresh, logic metric);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= CFG_DATA_W'(width);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(height);
		@(posedge clk);
		cfg_index <= REG_EDGE_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'(thresh);
		@(posedge clk);
		cfg_index <= REG_METRIC_MODE;
		cfg_wdata <= CFG_DATA_W'(metric);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One frame plus its flush. Colors wander around a base by up to the threshold plus one,
	// so differences land on both sides of it; stray drain ticks are mixed in.
	task automatic run_frame(int width, int height, int spread);
		rgb_t base, colour;
		int   n, k, v;
		base = rgb_t'($urandom());
		for (n = 0; n < width * height; n++) begin
			if ($urandom_range(0, 15) == 0) send(OP_DRAIN, rgb_t'($urandom()));
			case ($urandom_range(0, 7))
				0: colour = rgb_t'($urandom());
				1, 2, 3: colour = base;
				default: begin
					for (k = 0; k < 3; k++) begin
						v = int'(base[8*k +: 8]) + int'($urandom_range(0, 2 * spread + 2))
							- spread - 1;
						if (v < 0) v = 0;
						if (v > 255) v = 255;
						colour[8*k +: 8] = 8'(v);
					end
				end
			endcase
			if ($urandom_range(0, 3) == 0) base = colour;
			send(OP_PIXEL, colour);
			stream_items++;
		end
		// A pixel sent during the flush stands in for a drain tick.
		for (n = 0; n <= width; n++) begin
			if ($urandom_range(0, 3) == 0) send(OP_PIXEL, rgb_t'($urandom()));
			else send(OP_DRAIN, rgb_t'($urandom()));
			stream_items++;
		end
		frames_sent++;
	endtask

	initial begin : stimulus
		int   width, height, thresh, random_start;
		logic metric;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lowest threshold on a tiny frame, with drain ticks outside and inside the frame.
		load_settings(3, 2, 1, METRIC_MAX);
		send(OP_DRAIN, 24'h123456);
		send(OP_PIXEL, 24'h000000);
		send(OP_PIXEL, 24'hFFFFFF);
		send(OP_PIXEL, 24'h000001);
		send(OP_DRAIN, 24'hABCDEF);
		send(OP_PIXEL, 24'h000002);
		send(OP_PIXEL, 24'h000000);
		send(OP_PIXEL, 24'h000000);
		send(OP_DRAIN, 24'h000000);
		send(OP_PIXEL, 24'hFFFFFF);
		send(OP_DRAIN, 24'h000000);
		send(OP_DRAIN, 24'h000000);
		settle();

		// One column in Euclidean mode: black against white only just exceeds 440.
		load_settings(1, 3, 440, METRIC_EUCLID);
		send(OP_PIXEL, 24'h000000);
		send(OP_PIXEL, 24'hFFFFFF);
		send(OP_PIXEL, 24'hFEFFFF);
		send(OP_DRAIN, 24'hFFFFFF);
		send(OP_DRAIN, 24'h000000);
		settle();

		// Size and threshold extremes.
		load_settings(1, 1, 1, METRIC_MAX);
		run_frame(1, 1, 1);
		settle();
		load_settings(24, 2, 511, METRIC_MAX);
		run_frame(24, 2, 511);
		settle();
		load_settings(1, 24, 511, METRIC_EUCLID);
		run_frame(1, 24, 511);
		settle();

		// Output held off while the input keeps coming, so the block has to stall its input.
		load_settings(12, 8, 20, METRIC_MAX);
		hold_req <= hold_req + 1;
		run_frame(12, 8, 20);
		settle();

		random_start = stream_items;
		while (stream_items - random_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: begin
					width = $urandom_range(41, 80);
					height = $urandom_range(1, 2);
				end
				1, 2, 3, 4: begin
					width = $urandom_range(13, 40);
					height = $urandom_range(1, 3);
				end
				default: begin
					width = $urandom_range(1, 12);
					height = $urandom_range(1, 6);
				end
			endcase
			case ($urandom_range(0, 7))
				0: thresh = 1;
				1: thresh = 511;
				2: thresh = $urandom_range(1, 511);
				default: thresh = $urandom_range(1, 48);
			endcase
			metric = ($urandom_range(0, 1) == 1) ? METRIC_EUCLID : METRIC_MAX;
			settle();
			load_settings(width, height, thresh, metric);
			repeat ((width * height > 40) ? 1 : $urandom_range(1, 3))
				run_frame(width, height, thresh);
		end

		settle();
		repeat (6) @(posedge clk);
		$display("Sent %0d requests in %0d frames; %0d marks checked, %0d of them edges.",
			requests_sent, frames_sent, marks_checked, edge_marks);
		$display("Widths 1 to 80, heights 1 to 24, thresholds 1 to 511, both metrics, %0d cycles.",
			cycle_count);
		if (mark_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cded_pkg.sv
rtl/core/cded_line_ram.sv
rtl/core/cded_eval.sv
rtl/core/color_difference_edge_detect_unit.sv
bench/color_difference_edge_detect_unit_checker.sv
bench/color_difference_edge_detect_unit_tb.sv
